[design/itrc_pkg.sv]
`default_nettype none

package itrc_pkg;

    // verdict codes
    localparam logic [1:0] VERDICT_IGNORE   = 2'd0;
    localparam logic [1:0] VERDICT_HOP      = 2'd1;
    localparam logic [1:0] VERDICT_REACHED  = 2'd2;

    // configuration register indexes
    localparam logic CFG_PROBE_ID  = 1'b0;
    localparam logic CFG_PROBE_SEQ = 1'b1;

    // icmp message types and header sizes
    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] ICMP_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
    localparam int unsigned ICMP_HDR_LEN      = 8;
    localparam int unsigned IP_MIN_HDR_LEN    = 20;

    // fields gathered from one packet
    typedef struct packed {
        logic [5:0]  outer_header_len;
        logic [31:0] source_addr;
        logic [15:0] outer_type_code;
        logic [31:0] outer_id_seq;
        logic [5:0]  inner_header_len;
        logic [15:0] inner_type_code;
        logic [31:0] inner_id_seq;
    } pkt_view_t;

endpackage

`default_nettype wire

[design/icmp_trace_reply_classifier.sv]
`default_nettype none

// channel   direction  handshake            payload
// pkt       in         pkt_valid/pkt_stall  packet_byte, last_byte
// res       out        res_valid/res_stall  verdict, hop_address
// cfg       in         cfg_write            cfg_index, cfg_data
//
// one packet byte is taken every cycle while pkt_stall is low.
// the input register feeds field capture and verdict logic combinationally;
// the result register takes the verdict as the final byte leaves the input register.
// pkt_stall rises only when a final byte waits on a full, stalled result register.
// reset clears the probe registers, packet state and both valid flags.
module icmp_trace_reply_classifier #(
    parameter int MAX_PACKET = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pkt_valid,
    output logic             pkt_stall,
    input  wire logic [7:0]  packet_byte,
    input  wire logic        last_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       verdict,
    output logic [31:0]      hop_address,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int OFF_W = $clog2(MAX_PACKET + 1);

    logic [15:0] probe_id_reg;
    logic [15:0] probe_seq_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        advance;
    logic        finish;
    logic        res_valid_next;

    itrc_pkg::pkt_view_t view_next;
    logic [OFF_W-1:0]    count_next;
    logic [1:0]          verdict_calc;
    logic [31:0]         hop_calc;
    logic [1:0]          verdict_reg;
    logic [31:0]         hop_reg;
    logic                res_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_id_reg  <= '0;
            probe_seq_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                itrc_pkg::CFG_PROBE_ID:  probe_id_reg  <= cfg_data;
                itrc_pkg::CFG_PROBE_SEQ: probe_seq_reg <= cfg_data;
                default:                 probe_id_reg  <= probe_id_reg;
            endcase
        end
    end

    // flow control: only a final byte needs a free result slot
    assign advance   = !in_last_reg || !res_valid_reg || !res_stall;
    assign finish    = in_valid_reg && in_last_reg && advance;
    assign pkt_stall = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!pkt_stall)
            in_valid_reg <= pkt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!pkt_stall)
        begin
            in_byte_reg <= packet_byte;
            in_last_reg <= last_byte;
        end
    end

    itrc_parse #(
        .MAX_PACKET (MAX_PACKET),
        .OFF_W      (OFF_W)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_valid_reg && advance),
        .data_byte  (in_byte_reg),
        .last       (in_last_reg),
        .view_next  (view_next),
        .count_next (count_next)
    );

    itrc_classify #(
        .OFF_W       (OFF_W)
    ) u_classify (
        .count       (count_next),
        .view        (view_next),
        .probe_id    (probe_id_reg),
        .probe_seq   (probe_seq_reg),
        .verdict     (verdict_calc),
        .hop_address (hop_calc)
    );

    // result register
    always_comb
    begin
        if (finish)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            verdict_reg <= verdict_calc;
            hop_reg     <= hop_calc;
        end
    end

    assign res_valid   = res_valid_reg;
    assign verdict     = verdict_reg;
    assign hop_address = hop_reg;

    // an ignored packet never reports an address
    a_ignore_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && verdict == itrc_pkg::VERDICT_IGNORE |-> hop_address == 32'd0)
        else $error("ignored verdict carries an address");

    // the input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_stall |-> in_valid_reg && in_last_reg && res_valid && res_stall)
        else $error("input stalled without a blocked result");

    // a verdict code is never the unused value
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> verdict == itrc_pkg::VERDICT_IGNORE || verdict == itrc_pkg::VERDICT_HOP
                      || verdict == itrc_pkg::VERDICT_REACHED)
        else $error("unused verdict code");

    // a final byte taken into the pipe yields a result next cycle
    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> res_valid)
        else $error("final byte produced no result");

endmodule

`default_nettype wire

[design/itrc_parse.sv]
`default_nettype none

module itrc_parse #(
    parameter int MAX_PACKET = 2048,
    parameter int OFF_W      = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last,
    output itrc_pkg::pkt_view_t     view_next,
    output logic [OFF_W-1:0]        count_next
);

    localparam int CMP_W = OFF_W + 2;

    itrc_pkg::pkt_view_t view_reg;
    logic [OFF_W-1:0]    count_reg;

    logic             in_range;
    logic [CMP_W-1:0] off_w;
    logic [CMP_W-1:0] icmp1_w;
    logic [CMP_W-1:0] ip2_w;
    logic [CMP_W-1:0] icmp2_w;
    logic [CMP_W-1:0] d1;
    logic [CMP_W-1:0] d2;
    logic             past1;
    logic             past2;

    // field capture for the byte at the current offset
    always_comb
    begin
        view_next  = view_reg;
        count_next = count_reg;
        in_range   = count_reg < OFF_W'(MAX_PACKET);
        off_w      = CMP_W'(count_reg);
        icmp1_w    = '0;
        ip2_w      = '0;
        icmp2_w    = '0;
        d1         = '0;
        d2         = '0;
        past1      = 1'b0;
        past2      = 1'b0;
        if (in_range)
        begin
            count_next = count_reg + OFF_W'(1);

            // outer header length from the ihl nibble of byte 0
            if (count_reg == '0)
                view_next.outer_header_len = {data_byte[3:0], 2'b00};

            // source address, bytes 12 to 15
            if (off_w >= CMP_W'(12) && off_w <= CMP_W'(15))
            begin
                case (count_reg[1:0])
                    2'd0:    view_next.source_addr[31:24] = data_byte;
                    2'd1:    view_next.source_addr[23:16] = data_byte;
                    2'd2:    view_next.source_addr[15:8]  = data_byte;
                    default: view_next.source_addr[7:0]   = data_byte;
                endcase
            end

            // outer icmp header
            icmp1_w = CMP_W'(view_next.outer_header_len);
            past1   = off_w >= icmp1_w;
            d1      = off_w - icmp1_w;
            if (past1 && d1 < CMP_W'(2))
            begin
                if (d1[0] == 1'b0)
                    view_next.outer_type_code[15:8] = data_byte;
                else
                    view_next.outer_type_code[7:0] = data_byte;
            end
            if (past1 && d1 >= CMP_W'(4) && d1 < CMP_W'(8))
            begin
                case (d1[1:0])
                    2'd0:    view_next.outer_id_seq[31:24] = data_byte;
                    2'd1:    view_next.outer_id_seq[23:16] = data_byte;
                    2'd2:    view_next.outer_id_seq[15:8]  = data_byte;
                    default: view_next.outer_id_seq[7:0]   = data_byte;
                endcase
            end

            // quoted ip header length
            ip2_w = icmp1_w + CMP_W'(itrc_pkg::ICMP_HDR_LEN);
            if (off_w == ip2_w)
                view_next.inner_header_len = {data_byte[3:0], 2'b00};

            // quoted icmp header
            icmp2_w = ip2_w + CMP_W'(view_next.inner_header_len);
            past2   = off_w >= icmp2_w;
            d2      = off_w - icmp2_w;
            if (past2 && d2 < CMP_W'(2))
            begin
                if (d2[0] == 1'b0)
                    view_next.inner_type_code[15:8] = data_byte;
                else
                    view_next.inner_type_code[7:0] = data_byte;
            end
            if (past2 && d2 >= CMP_W'(4) && d2 < CMP_W'(8))
            begin
                case (d2[1:0])
                    2'd0:    view_next.inner_id_seq[31:24] = data_byte;
                    2'd1:    view_next.inner_id_seq[23:16] = data_byte;
                    2'd2:    view_next.inner_id_seq[15:8]  = data_byte;
                    default: view_next.inner_id_seq[7:0]   = data_byte;
                endcase
            end
        end
    end

    // packet state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg  <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                view_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                view_reg  <= view_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/itrc_classify.sv]
`default_nettype none

module itrc_classify #(
    parameter int OFF_W = 12
) (
    input  wire logic [OFF_W-1:0]      count,
    input  wire itrc_pkg::pkt_view_t   view,
    input  wire logic [15:0]           probe_id,
    input  wire logic [15:0]           probe_seq,
    output logic [1:0]                 verdict,
    output logic [31:0]                hop_address
);

    localparam int CMP_W = OFF_W + 2;

    logic [CMP_W-1:0] n;
    logic [CMP_W-1:0] need_icmp;
    logic [CMP_W-1:0] need_quote;
    logic [CMP_W-1:0] need_inner;
    logic [31:0]      ours;
    logic [7:0]       otype;
    logic [7:0]       ocode;

    // length checks and probe match
    always_comb
    begin
        n          = CMP_W'(count);
        need_icmp  = CMP_W'(view.outer_header_len) + CMP_W'(itrc_pkg::ICMP_HDR_LEN);
        need_quote = need_icmp + CMP_W'(itrc_pkg::IP_MIN_HDR_LEN);
        need_inner = need_icmp + CMP_W'(view.inner_header_len)
                   + CMP_W'(itrc_pkg::ICMP_HDR_LEN);
        ours       = {probe_id, probe_seq};
        otype      = view.outer_type_code[15:8];
        ocode      = view.outer_type_code[7:0];
        verdict    = itrc_pkg::VERDICT_IGNORE;
        if (n >= need_icmp)
        begin
            if (otype == itrc_pkg::ICMP_TIME_EXCEEDED && ocode == 8'd0)
            begin
                if (n >= need_quote && n >= need_inner
                    && view.inner_type_code == {itrc_pkg::ICMP_ECHO_REQUEST, 8'd0}
                    && view.inner_id_seq == ours)
                    verdict = itrc_pkg::VERDICT_HOP;
            end
            else if (otype == itrc_pkg::ICMP_ECHO_REPLY && view.outer_id_seq == ours)
                verdict = itrc_pkg::VERDICT_REACHED;
        end
        hop_address = (verdict != itrc_pkg::VERDICT_IGNORE) ? view.source_addr : 32'd0;
    end

endmodule

`default_nettype wire
